>>> sv/fbfa_pkg.sv
// ----------------------------------------------------------------------------
// fbfa_pkg: shared types and constants of the fixed block pool allocator
// Pool geometry, item layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package fbfa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS   = 1024;
  localparam int HEADER_BYTES = 0;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int LINK_W       = $clog2(MAX_BLOCKS + 1);
  localparam int ENTRY_W      = LINK_W + 1;  // {in_use, next_link}

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_INIT    = 2'd2;
  localparam logic [1:0] KIND_DISPOSE = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOT_INIT = 3'd2;
  localparam logic [2:0] ST_ALREADY  = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [1:0] CFG_POOL_BYTES  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd2;
  localparam logic [1:0] CFG_ALIGN_SHIFT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [10:0] allocation_count;
    logic        initialized;
  } out_item_t;

  // Pool geometry computed for an initialize request.
  typedef struct packed {
    logic              done;
    logic [31:0]       base;
    logic [4:0]        shift;
    logic [LINK_W-1:0] count;
  } geom_t;

endpackage

>>> sv/fixed_block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core: fixed-size block pool allocator
// Keeps a LIFO free list of equal blocks; each block's next link and in-use
// bit live together in one synchronous RAM entry.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | kind, free_address
//   out     | output    | out_valid/out_stall| address, status, counters
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// An allocate passes S_ALLOC, and a free S_FREE_OFF, S_FREE_CHK and S_FREE_WB
// (S_FREE_OFF only when null or unbuilt), before S_DONE; a dispose or refused
// initialize goes straight to S_DONE. A build waits in S_INIT_WAIT; S_INIT_WALK
// writes each entry once over the one write port; one item is in flight at a time.
// Reset is synchronous with no clearing pass; only linked entries are read.
// A result waits in the output register while the next beat is accepted; the
// sequencer holds its finished state only while that register is still full.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbfa_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import fbfa_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ALLOC     = 4'd1;
  localparam logic [3:0] S_FREE_OFF  = 4'd2;
  localparam logic [3:0] S_FREE_CHK  = 4'd3;
  localparam logic [3:0] S_FREE_WB   = 4'd4;
  localparam logic [3:0] S_INIT_WAIT = 4'd5;
  localparam logic [3:0] S_INIT_WALK = 4'd6;
  localparam logic [3:0] S_DONE      = 4'd7;

  // Configuration registers.
  logic [31:0] pool_base;
  logic [31:0] pool_bytes;
  logic [4:0]  block_shift;
  logic [2:0]  align_shift;

  // Pool state.
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] block_total;
  logic [31:0]       aligned_base;
  logic [31:0]       used_total;
  logic [LINK_W-1:0] live_count;
  logic              ready_flag;
  logic [4:0]        held_shift;

  // Sequencer.
  logic [3:0]        state;
  logic [31:0]       req_addr;
  logic [31:0]       res_addr;
  logic [2:0]        res_status;
  logic [31:0]       off;
  logic              off_lt;
  logic [IDX_W-1:0]  free_blk;
  logic [LINK_W-1:0] walk_idx;

  logic              in_accept;
  logic              geom_start;
  geom_t             geom;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [31:0]       block_bytes;
  logic [31:0]       alloc_addr;
  logic              head_ok;
  logic [32:0]       off_full;
  logic [31:0]       blk_w;
  logic              free_pass;
  logic [LINK_W-1:0] walk_plus;
  logic [LINK_W-1:0] walk_link;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign geom_start = in_accept && (in_data.kind == KIND_INIT) && !ready_flag &&
                      (pool_base != 32'd0);

  // Datapath terms of the individual request kinds.
  always_comb begin
    block_bytes = 32'd1 << held_shift;
    head_ok     = free_head < block_total;
    alloc_addr  = aligned_base + (32'(free_head) << held_shift) + 32'(HEADER_BYTES);
    off_full    = {1'b0, req_addr - 32'(HEADER_BYTES)} - {1'b0, aligned_base};
    blk_w       = off >> held_shift;
    free_pass   = !off_lt && ((off & (block_bytes - 32'd1)) == 32'd0) &&
                  (blk_w < 32'(block_total));
    walk_plus   = walk_idx + 1'b1;
    walk_link   = (walk_plus < block_total) ? walk_plus : NULL_LINK;
  end

  // Link RAM port control. An allocate or a free reads an entry and writes it
  // back in the next cycle; an initialize only writes; requests never overlap.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        // Prefetch the head entry so that a pop completes in the next cycle.
        ram_re    = in_accept && (in_data.kind == KIND_ALLOC);
        ram_raddr = free_head[IDX_W-1:0];
      end
      S_ALLOC: begin
        ram_we    = ready_flag && head_ok;
        ram_waddr = free_head[IDX_W-1:0];
        ram_wdata = {1'b1, ram_rdata[LINK_W-1:0]};
      end
      S_FREE_CHK: begin
        ram_re    = free_pass;
        ram_raddr = blk_w[IDX_W-1:0];
      end
      S_FREE_WB: begin
        ram_we    = ram_rdata[LINK_W];
        ram_waddr = free_blk;
        ram_wdata = {1'b0, free_head};
      end
      S_INIT_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = walk_idx[IDX_W-1:0];
        ram_wdata = {1'b0, walk_link};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= 32'd0;
      pool_bytes   <= 32'd0;
      block_shift  <= 5'd3;
      align_shift  <= 3'd0;
      free_head    <= NULL_LINK;
      block_total  <= '0;
      aligned_base <= 32'd0;
      used_total   <= 32'd0;
      live_count   <= '0;
      ready_flag   <= 1'b0;
      held_shift   <= 5'd3;
      state        <= S_IDLE;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POOL_BASE:   pool_base   <= cfg_data;
          CFG_POOL_BYTES:  pool_bytes  <= cfg_data;
          CFG_BLOCK_SHIFT: block_shift <= cfg_data[4:0];
          CFG_ALIGN_SHIFT: align_shift <= cfg_data[2:0];
        endcase
      end

      // In the finished state the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_addr <= in_data.free_address;
            res_addr <= 32'd0;
            unique case (in_data.kind)
              KIND_ALLOC: state <= S_ALLOC;
              KIND_FREE:  state <= S_FREE_OFF;
              KIND_INIT: begin
                if (ready_flag) begin
                  res_status <= ST_ALREADY;
                  state      <= S_DONE;
                end else if (pool_base == 32'd0) begin
                  res_status <= ST_NOT_INIT;
                  state      <= S_DONE;
                end else begin
                  state <= S_INIT_WAIT;
                end
              end
              KIND_DISPOSE: begin
                free_head    <= NULL_LINK;
                block_total  <= '0;
                aligned_base <= 32'd0;
                used_total   <= 32'd0;
                live_count   <= '0;
                ready_flag   <= 1'b0;
                held_shift   <= 5'd3;
                res_status   <= ST_OK;
                state        <= S_DONE;
              end
            endcase
          end
        end

        S_ALLOC: begin
          if (!ready_flag) begin
            res_status <= ST_NOT_INIT;
          end else if (!head_ok) begin
            res_status <= ST_EMPTY;
          end else begin
            res_status <= ST_OK;
            res_addr   <= alloc_addr;
            free_head  <= ram_rdata[LINK_W-1:0];
            used_total <= used_total + block_bytes;
            live_count <= live_count + 1'b1;
          end
          state <= S_DONE;
        end

        S_FREE_OFF: begin
          off    <= off_full[31:0];
          off_lt <= off_full[32];
          if (req_addr == 32'd0) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (!ready_flag) begin
            res_status <= ST_NOT_INIT;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_CHK;
          end
        end

        S_FREE_CHK: begin
          free_blk <= blk_w[IDX_W-1:0];
          if (free_pass) begin
            state <= S_FREE_WB;
          end else begin
            res_status <= ST_BAD;
            state      <= S_DONE;
          end
        end

        S_FREE_WB: begin
          // A block that is not handed out cannot be freed twice.
          if (ram_rdata[LINK_W]) begin
            free_head  <= LINK_W'(free_blk);
            used_total <= used_total - block_bytes;
            live_count <= live_count - 1'b1;
            res_status <= ST_OK;
          end else begin
            res_status <= ST_BAD;
          end
          state <= S_DONE;
        end

        S_INIT_WAIT: begin
          if (geom.done) begin
            aligned_base <= geom.base;
            held_shift   <= geom.shift;
            block_total  <= geom.count;
            free_head    <= (geom.count != '0) ? '0 : NULL_LINK;
            used_total   <= 32'd0;
            live_count   <= '0;
            ready_flag   <= 1'b1;
            walk_idx     <= '0;
            res_status   <= ST_OK;
            state        <= (geom.count != '0) ? S_INIT_WALK : S_DONE;
          end
        end

        S_INIT_WALK: begin
          walk_idx <= walk_plus;
          if (walk_plus == block_total) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.address          <= res_addr;
            out_data.status           <= res_status;
            out_data.used_bytes       <= used_total;
            out_data.allocation_count <= 11'(live_count);
            out_data.initialized      <= ready_flag;
            state                     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fbfa_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .start       (geom_start),
    .pool_base   (pool_base),
    .pool_bytes  (pool_bytes),
    .block_shift (block_shift),
    .align_shift (align_shift),
    .geom        (geom)
  );

  fbfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // Live allocations never exceed the blocks of the pool.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= block_total)
    else $error("live allocation count exceeds pool block count");

  // Bytes in use always equal the live count times the block size.
  a_used_bytes: assert property (@(posedge clk) disable iff (rst)
    used_total == (32'(live_count) << held_shift))
    else $error("used byte total out of step with live count");

  // A non-null free list head always names a block of the pool.
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    (free_head != NULL_LINK) |-> (ready_flag && (free_head < block_total)))
    else $error("free list head outside the pool");

  // The geometry result arrives only while the sequencer waits for it.
  a_geom_wait: assert property (@(posedge clk) disable iff (rst)
    geom.done |-> (state == S_INIT_WAIT))
    else $error("pool geometry result without a pending initialize");
`endif

endmodule

>>> sv/fbfa_ram.sv
// ----------------------------------------------------------------------------
// fbfa_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/fbfa_geom.sv
// ----------------------------------------------------------------------------
// fbfa_geom: pool geometry unit
// Two-stage pipeline that aligns the pool base and counts whole blocks.
// ----------------------------------------------------------------------------
module fbfa_geom (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [31:0]     pool_base,
  input  logic [31:0]     pool_bytes,
  input  logic [4:0]      block_shift,
  input  logic [2:0]      align_shift,
  output fbfa_pkg::geom_t geom
);
  import fbfa_pkg::*;

  logic [4:0]  sh;
  logic [7:0]  amask;
  logic [7:0]  adj;
  logic [32:0] base_w;

  logic        s1_valid;
  logic [4:0]  s1_sh;
  logic [32:0] s1_base;
  logic        s1_ok;
  logic [31:0] s1_room;

  logic [32:0] cnt;
  logic [32:0] lim;
  logic [32:0] fit;
  logic [32:0] capped;

  // Stage 1: clamp the shift and round the base up to the alignment.
  always_comb begin
    if (block_shift < 5'd3) begin
      sh = 5'd3;
    end else if (block_shift > 5'd16) begin
      sh = 5'd16;
    end else begin
      sh = block_shift;
    end
    amask  = 8'((16'd1 << align_shift) - 16'd1);
    adj    = (8'd0 - pool_base[7:0]) & amask;
    base_w = {1'b0, pool_base} + 33'(adj);
  end

  // Stage 2: blocks that fit in the room and below the top of the address space, capped at MAX_BLOCKS.
  always_comb begin
    cnt    = 33'(s1_room) >> s1_sh;
    lim    = (33'h1_0000_0000 - s1_base) >> s1_sh;
    fit    = (cnt > lim) ? lim : cnt;
    capped = (fit > 33'(MAX_BLOCKS)) ? 33'(MAX_BLOCKS) : fit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      geom.done <= 1'b0;
    end else begin
      s1_valid  <= start;
      geom.done <= s1_valid;
    end
    s1_sh      <= sh;
    s1_base    <= base_w;
    s1_ok      <= (pool_bytes >= 32'(adj)) && !base_w[32];
    s1_room    <= pool_bytes - 32'(adj);
    geom.base  <= s1_base[31:0];
    geom.shift <= s1_sh;
    geom.count <= s1_ok ? LINK_W'(capped) : '0;
  end

endmodule

>>> sim/fbfa_tb_pkg.sv
// ----------------------------------------------------------------------------
// fbfa_tb_pkg: pool allocator scoreboard
// Predicts the result beat of every accepted request from a private copy of
// the pool state and configuration, and compares it with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package fbfa_tb_pkg;
  import fbfa_pkg::*;

  class pool_scoreboard;
    // Configuration registers as last written.
    logic [31:0] pool_base;
    logic [31:0] pool_bytes;
    logic [4:0]  block_shift;
    logic [2:0]  align_shift;

    // Pool state.
    logic [LINK_W-1:0] next_link [MAX_BLOCKS];
    bit                in_use [MAX_BLOCKS];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] block_total;
    logic [LINK_W-1:0] live_count;
    logic [31:0]       aligned_base;
    logic [31:0]       used_total;
    logic [4:0]        held_shift;
    bit                ready_flag;

    // User addresses currently handed out, for well-formed frees.
    logic [31:0] live_addrs [$];
    // Result beats still owed by the block, oldest first.
    out_item_t   owed_replies [$];

    int errors;
    int checked;
    int pools_built;

    function new();
      pool_base   = '0;
      pool_bytes  = '0;
      block_shift = 5'd3;
      align_shift = '0;
      foreach (next_link[i]) next_link[i] = '0;
      errors      = 0;
      checked     = 0;
      pools_built = 0;
      clear_pool();
    endfunction

    function void clear_pool();
      foreach (in_use[i]) in_use[i] = 1'b0;
      free_head    = NULL_LINK;
      block_total  = '0;
      aligned_base = '0;
      used_total   = '0;
      live_count   = '0;
      ready_flag   = 1'b0;
      held_shift   = 5'd3;
      live_addrs.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_POOL_BASE:   pool_base   = data;
        CFG_POOL_BYTES:  pool_bytes  = data;
        CFG_BLOCK_SHIFT: block_shift = data[4:0];
        CFG_ALIGN_SHIFT: align_shift = data[2:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] build_pool();
      logic [63:0] align;
      logic [63:0] adj;
      logic [63:0] base;
      logic [63:0] room;
      logic [63:0] count;
      logic [63:0] limit;
      logic [4:0]  sh;
      int          i;
      if (ready_flag) return ST_ALREADY;
      if (pool_base == 0) return ST_NOT_INIT;
      sh    = (block_shift < 3) ? 5'd3 : ((block_shift > 16) ? 5'd16 : block_shift);
      align = 64'd1 << align_shift;
      adj   = (align - ({32'd0, pool_base} & (align - 1))) & (align - 1);
      base  = {32'd0, pool_base} + adj;
      count = '0;
      if ({32'd0, pool_bytes} >= adj && base < (64'd1 << 32)) begin
        room  = {32'd0, pool_bytes} - adj;
        count = room >> sh;
        limit = ((64'd1 << 32) - base) >> sh;
        if (count > limit) count = limit;
        if (count > MAX_BLOCKS) count = MAX_BLOCKS;
      end
      clear_pool();
      held_shift   = sh;
      aligned_base = base[31:0];
      block_total  = count[LINK_W-1:0];
      for (i = 0; i < count; i++)
        next_link[i] = (i + 1 < count) ? LINK_W'(i + 1) : NULL_LINK;
      free_head   = (count > 0) ? '0 : NULL_LINK;
      ready_flag  = 1'b1;
      pools_built++;
      return ST_OK;
    endfunction

    function logic [2:0] pop_block(output logic [31:0] addr);
      logic [LINK_W-1:0] blk;
      addr = '0;
      if (!ready_flag) return ST_NOT_INIT;
      if (free_head >= block_total) return ST_EMPTY;
      blk         = free_head;
      addr        = aligned_base + (32'(blk) << held_shift) + 32'(HEADER_BYTES);
      free_head   = next_link[blk];
      in_use[blk] = 1'b1;
      used_total  = used_total + (32'd1 << held_shift);
      live_count  = live_count + 1'b1;
      live_addrs.push_back(addr);
      return ST_OK;
    endfunction

    function logic [2:0] push_block(logic [31:0] user);
      logic [31:0] blockaddr;
      logic [31:0] off;
      logic [31:0] blk;
      int          i;
      if (user == 0) return ST_OK;
      if (!ready_flag) return ST_NOT_INIT;
      blockaddr = user - 32'(HEADER_BYTES);
      if (blockaddr < aligned_base) return ST_BAD;
      off = blockaddr - aligned_base;
      if ((off & ((32'd1 << held_shift) - 1)) != 0) return ST_BAD;
      blk = off >> held_shift;
      if (blk >= 32'(block_total)) return ST_BAD;
      if (!in_use[blk[IDX_W-1:0]]) return ST_BAD;
      in_use[blk[IDX_W-1:0]]    = 1'b0;
      next_link[blk[IDX_W-1:0]] = free_head;
      free_head  = blk[LINK_W-1:0];
      used_total = used_total - (32'd1 << held_shift);
      live_count = live_count - 1'b1;
      for (i = 0; i < live_addrs.size(); i++) begin
        if (live_addrs[i] == user) begin
          live_addrs.delete(i);
          break;
        end
      end
      return ST_OK;
    endfunction

    // Called once per accepted request beat.
    function void note_request(in_item_t req);
      out_item_t   rep;
      logic [31:0] addr;
      logic [2:0]  st;
      addr = '0;
      case (req.kind)
        KIND_ALLOC: st = pop_block(addr);
        KIND_FREE:  st = push_block(req.free_address);
        KIND_INIT:  st = build_pool();
        default: begin
          clear_pool();
          st = ST_OK;
        end
      endcase
      rep.address          = addr;
      rep.status           = st;
      rep.used_bytes       = used_total;
      rep.allocation_count = live_count;
      rep.initialized      = ready_flag;
      owed_replies.push_back(rep);
    endfunction

    // Called once per accepted result beat.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (owed_replies.size() == 0) begin
        $error("result beat with no request outstanding: address %h status %0d",
               got.address, got.status);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (got.address !== want.address) begin
        $error("address: expected %h, got %h", want.address, got.address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.used_bytes !== want.used_bytes) begin
        $error("used_bytes: expected %h, got %h", want.used_bytes, got.used_bytes);
        errors++;
      end
      if (got.allocation_count !== want.allocation_count) begin
        $error("allocation_count: expected %0d, got %0d",
               want.allocation_count, got.allocation_count);
        errors++;
      end
      if (got.initialized !== want.initialized) begin
        $error("initialized: expected %0b, got %0b", want.initialized, got.initialized);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the fixed block pool allocator
// Drives allocate, free, initialize and dispose requests through the
// valid/stall request channel, writes the pool registers between phases, and
// checks every result beat against a scoreboard that tracks the free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
  import fbfa_pkg::*;
  import fbfa_tb_pkg::*;

  // Random requests after the directed part, spread over three idle phases.
  localparam int RANDOM_ITEMS = 600;
  // Far above the slowest correct run: a few 1024-block initializations plus
  // several hundred short requests, each waiting out random gaps and stalls.
  localparam int CYCLE_LIMIT  = 500000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int src_idle = 24;
  int dst_idle = 52;
  int cycles   = 0;
  int sent     = 0;

  pool_scoreboard sb;

  fixed_block_free_list_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_idle);
  end

  // Every result beat taken at an edge is checked against the oldest
  // prediction. Signals are read before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_reply(out_data);
  end

  // Presents one request beat after a random gap and returns at the edge
  // where it was taken. The prediction is made right there, so the next
  // request can be built from the state that this one leaves.
  task automatic send_request(logic [1:0] kind, logic [31:0] faddr);
    in_item_t req;
    req.kind         = kind;
    req.free_address = faddr;
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    sent++;
  endtask

  // Holds the sender back until every owed result beat has come out, then
  // lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all four pool registers while the block is idle. The write
  // enable stays high across the four writes and drops after the last one.
  task automatic set_pool(logic [31:0] base, logic [31:0] bytes,
                          logic [4:0] bshift, logic [2:0] ashift);
    logic [31:0] vals [4];
    logic [1:0]  idxs [4];
    int          i;
    vals[0] = base;
    vals[1] = bytes;
    vals[2] = {27'd0, bshift};
    vals[3] = {29'd0, ashift};
    idxs[0] = CFG_POOL_BASE;
    idxs[1] = CFG_POOL_BYTES;
    idxs[2] = CFG_BLOCK_SHIFT;
    idxs[3] = CFG_ALIGN_SHIFT;
    drain();
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          phase_end;
    int          n_ops;
    int          r;
    int          k;
    int          sh;
    logic [31:0] a;
    logic [31:0] base;
    logic [31:0] bytes;
    logic [4:0]  bsh;
    logic [2:0]  ash;

    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle = 24;
          dst_idle = 52;
        end
        1: begin
          src_idle = 52;
          dst_idle = 24;
        end
        default: begin
          src_idle = 0;
          dst_idle = 0;
        end
      endcase

      if (ph == 0) begin
        // Before any initialize: allocate and a non-null free are refused,
        // a null free is harmless, and a pool at address zero will not build.
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_FREE, 32'h0);
        send_request(KIND_FREE, 32'hFFFF_FFFF);
        send_request(KIND_INIT, 32'h0);
        send_request(KIND_DISPOSE, 32'hFFFF_FFFF);

        // Block size below the minimum is raised to 8 bytes, and the base is
        // aligned up to 16 bytes: four blocks at 0x1010.
        set_pool(32'h0000_1003, 32'd48, 5'd0, 3'd4);
        send_request(KIND_INIT, 32'h0);
        send_request(KIND_INIT, 32'h0);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_ALLOC, 32'h0);
        // Misaligned, below the pool, a block never handed out, past the end.
        send_request(KIND_FREE, 32'h0000_1011);
        send_request(KIND_FREE, 32'h0000_1008);
        send_request(KIND_FREE, 32'h0000_1020);
        send_request(KIND_FREE, 32'h0000_1030);
        // A good free, then the same block again.
        send_request(KIND_FREE, 32'h0000_1010);
        send_request(KIND_FREE, 32'h0000_1010);
        // Take the rest of the pool, then one more to hit the empty case.
        repeat (4) send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_DISPOSE, 32'h0);
        send_request(KIND_ALLOC, 32'h0);

        // Aligning the base runs past the top of the address space and the
        // block size is clamped to 64 KiB: a pool with no blocks at all.
        set_pool(32'hFFFF_FFF1, 32'hFFFF_FFFF, 5'd31, 3'd7);
        send_request(KIND_INIT, 32'h0);
        send_request(KIND_ALLOC, 32'h0);

        // Largest pool: the block count saturates at the link memory depth.
        set_pool(32'h0000_0008, 32'hFFFF_FFFF, 5'd3, 3'd3);
        send_request(KIND_INIT, 32'h0);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_FREE, 32'h0000_0008);
      end

      phase_end = sent + RANDOM_ITEMS / 3;
      while (sent < phase_end) begin
        // A new pool shape for each session. Most pools are small so that
        // the empty case comes up; a few hit the extremes.
        bsh  = 5'($urandom_range(0, 31));
        ash  = 3'($urandom_range(0, 7));
        base = $urandom;
        case ($urandom_range(15))
          0: begin
            base  = 32'h0;
            bytes = $urandom;
          end
          1: begin
            base  = $urandom_range(1, 4096);
            bytes = 32'hFFFF_FFFF;
            bsh   = 5'd3;
          end
          2: begin
            // Near the top of memory the count is cut so the last block ends
            // at or below the 4 GiB boundary.
            base  = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
            bytes = $urandom;
            bsh   = 5'($urandom_range(10, 16));
          end
          3: bytes = $urandom_range(0, 15);
          default: begin
            sh    = (bsh < 3) ? 3 : ((bsh > 16) ? 16 : int'(bsh));
            bytes = ($urandom_range(1, 24) << sh) + $urandom_range(0, 200);
          end
        endcase
        set_pool(base, bytes, bsh, ash);

        // Mostly well-formed traffic: allocations and frees of live blocks,
        // with some bad frees, re-initializations and disposes mixed in.
        send_request(KIND_INIT, $urandom);
        n_ops = $urandom_range(8, 40);
        repeat (n_ops) begin
          r = $urandom_range(99);
          if (r < 45 || (r < 80 && sb.live_addrs.size() == 0)) begin
            send_request(KIND_ALLOC, $urandom);
          end else if (r < 80) begin
            k = $urandom_range(0, sb.live_addrs.size() - 1);
            send_request(KIND_FREE, sb.live_addrs[k]);
          end else if (r < 88) begin
            case ($urandom_range(3))
              0: a = $urandom;
              1: a = sb.aligned_base + ($urandom_range(0, 40) << sb.held_shift)
                     + $urandom_range(1, (32'd1 << sb.held_shift) - 1);
              2: a = sb.aligned_base + ($urandom_range(0, sb.block_total + 2)
                     << sb.held_shift);
              default: a = sb.aligned_base - (32'd1 << sb.held_shift);
            endcase
            send_request(KIND_FREE, a);
          end else if (r < 91) begin
            send_request(KIND_FREE, 32'h0);
          end else if (r < 94) begin
            send_request(KIND_INIT, $urandom);
          end else if (r < 97) begin
            send_request(KIND_DISPOSE, $urandom);
          end else begin
            send_request(2'($urandom_range(0, 3)), $urandom);
          end
        end
        // Now and then the pool is left built, so the next initialize is
        // refused and the old pool keeps serving.
        if ($urandom_range(3) != 0) send_request(KIND_DISPOSE, $urandom);
      end
    end

    drain();
    $display("Run covered %0d request beats, %0d result beats checked, %0d pools built.",
             sent, sb.checked, sb.pools_built);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0 && sb.owed_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> fixed_block_free_list_allocator_core.f
sv/fbfa_pkg.sv
sv/fbfa_ram.sv
sv/fbfa_geom.sv
sv/fixed_block_free_list_allocator_core.sv
sim/fbfa_tb_pkg.sv
sim/tb_top.sv
